[design/clock_buffer_frame_manager_defines.svh]
// Assertion macros used by the frame manager controller.
`ifndef CLOCK_BUFFER_FRAME_MANAGER_DEFINES_SVH
`define CLOCK_BUFFER_FRAME_MANAGER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CBFM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define CBFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cbfm_pkg.sv]
package cbfm_pkg;

    localparam int OP_W   = 3;
    localparam int FILE_W = 8;
    localparam int PAGE_W = 32;
    localparam int PIN_W  = 16;
    localparam int FRM_W  = 4;
    localparam int ST_W   = 3;

    localparam logic [PIN_W-1:0] PIN_MAX = 16'hFFFF;

    localparam logic [OP_W-1:0] OP_READ    = 3'd0;
    localparam logic [OP_W-1:0] OP_UNPIN   = 3'd1;
    localparam logic [OP_W-1:0] OP_PLACE   = 3'd2;
    localparam logic [OP_W-1:0] OP_DISPOSE = 3'd3;
    localparam logic [OP_W-1:0] OP_FLUSH   = 3'd4;

    localparam logic [ST_W-1:0] STS_OK         = 3'd0;
    localparam logic [ST_W-1:0] STS_EXCEEDED   = 3'd1;
    localparam logic [ST_W-1:0] STS_NOT_PINNED = 3'd2;
    localparam logic [ST_W-1:0] STS_PINNED     = 3'd3;

    // One frame entry in the tag memory
    typedef struct packed {
        logic              ref_bit;
        logic              dirty;
        logic [PIN_W-1:0]  pins;
        logic [FILE_W-1:0] file_tag;
        logic [PAGE_W-1:0] page_tag;
    } frame_word_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_TOUCH,
        WR_UNPIN,
        WR_SWEEP_CLR,
        WR_FILL
    } wr_kind_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_HIT,
        RES_NOT_PINNED,
        RES_EXCEEDED,
        RES_FILL,
        RES_FLUSH,
        RES_PINNED
    } res_kind_t;

    typedef struct packed {
        logic      latch;
        logic      idx_clr;
        logic      idx_inc;
        logic      hand_inc;
        logic      steps_clr;
        logic      steps_inc;
        logic      use_hand;
        logic      mem_rd;
        wr_kind_t  wr;
        logic      valid_clr;
        logic      out_load;
        res_kind_t res;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            out_free;
        logic            match;
        logic            file_match;
        logic            busy;
        logic            pins_zero;
        logic            idx_last;
        logic            sweep_limit;
        logic            flush_last;
    } sts_t;

endpackage

[design/cbfm_req_if.sv]
interface cbfm_req_if;
    logic                         valid;
    logic                         ready;
    logic [cbfm_pkg::OP_W-1:0]    op;
    logic [cbfm_pkg::FILE_W-1:0]  file_id;
    logic [cbfm_pkg::PAGE_W-1:0]  page_no;
    logic                         mark_dirty;

    modport source (output valid, output op, output file_id, output page_no,
                    output mark_dirty, input ready);
    modport sink (input valid, input op, input file_id, input page_no,
                  input mark_dirty, output ready);
endinterface

[design/cbfm_rsp_if.sv]
interface cbfm_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [cbfm_pkg::FRM_W-1:0]   frame;
    logic                         hit;
    logic                         fetch;
    logic                         wb_valid;
    logic [cbfm_pkg::FILE_W-1:0]  wb_file;
    logic [cbfm_pkg::PAGE_W-1:0]  wb_page;
    logic [cbfm_pkg::ST_W-1:0]    status;
    logic                         last;

    modport source (output valid, output frame, output hit, output fetch,
                    output wb_valid, output wb_file, output wb_page,
                    output status, output last, input ready);
    modport sink (input valid, input frame, input hit, input fetch,
                  input wb_valid, input wb_file, input wb_page,
                  input status, input last, output ready);
endinterface

[design/cbfm_datapath.sv]
module cbfm_datapath #(
    parameter int NUM_FRAMES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cbfm_pkg::OP_W-1:0]     op,
    input  logic [cbfm_pkg::FILE_W-1:0]   file_id,
    input  logic [cbfm_pkg::PAGE_W-1:0]   page_no,
    input  logic                          mark_dirty,
    input  cbfm_pkg::cmd_t                cmd,
    output cbfm_pkg::sts_t                sts,
    cbfm_rsp_if.source                    rsp
);

    localparam int IW = $clog2(NUM_FRAMES);
    localparam int SW = $clog2(2 * NUM_FRAMES);
    localparam logic [IW-1:0] LAST_IDX    = IW'(NUM_FRAMES - 1);
    localparam logic [SW-1:0] SWEEP_LIMIT = SW'(2 * NUM_FRAMES - 2);
    localparam logic [SW-1:0] FLUSH_LAST  = SW'(NUM_FRAMES - 1);

    logic [cbfm_pkg::OP_W-1:0]    op_reg;
    logic [cbfm_pkg::FILE_W-1:0]  fid_reg;
    logic [cbfm_pkg::PAGE_W-1:0]  pno_reg;
    logic                         md_reg;
    logic [IW-1:0]                idx_reg;
    logic [IW-1:0]                hand_reg;
    logic [SW-1:0]                steps_reg;
    logic [NUM_FRAMES-1:0]        valid_reg;
    cbfm_pkg::frame_word_t        mem [NUM_FRAMES];
    cbfm_pkg::frame_word_t        rd_reg;
    cbfm_pkg::frame_word_t        wr_word;
    logic [IW-1:0]                addr;
    logic                         vld;

    logic                         out_valid_reg;
    logic [cbfm_pkg::FRM_W-1:0]   frame_reg, frame_next;
    logic                         hit_reg, hit_next;
    logic                         fetch_reg, fetch_next;
    logic                         wbv_reg, wbv_next;
    logic [cbfm_pkg::FILE_W-1:0]  wbf_reg, wbf_next;
    logic [cbfm_pkg::PAGE_W-1:0]  wbp_reg, wbp_next;
    logic [cbfm_pkg::ST_W-1:0]    status_reg, status_next;
    logic                         last_reg, last_next;

    assign addr = cmd.use_hand ? hand_reg : idx_reg;
    assign vld  = valid_reg[addr];

    always_comb
    begin
        sts.op          = op_reg;
        sts.out_free    = !out_valid_reg;
        sts.file_match  = vld && (rd_reg.file_tag == fid_reg);
        sts.match       = sts.file_match && (rd_reg.page_tag == pno_reg);
        sts.busy        = vld && (rd_reg.ref_bit || (rd_reg.pins != '0));
        sts.pins_zero   = (rd_reg.pins == '0);
        sts.idx_last    = (idx_reg == LAST_IDX);
        sts.sweep_limit = (steps_reg == SWEEP_LIMIT);
        sts.flush_last  = (steps_reg == FLUSH_LAST);
    end

    always_comb
    begin
        wr_word = rd_reg;
        case (cmd.wr)
            cbfm_pkg::WR_TOUCH:
            begin
                wr_word.ref_bit = 1'b1;
                if (rd_reg.pins != cbfm_pkg::PIN_MAX)
                    wr_word.pins = rd_reg.pins + cbfm_pkg::PIN_W'(1);
            end
            cbfm_pkg::WR_UNPIN:
            begin
                wr_word.pins  = rd_reg.pins - cbfm_pkg::PIN_W'(1);
                wr_word.dirty = rd_reg.dirty | md_reg;
            end
            cbfm_pkg::WR_SWEEP_CLR:
                wr_word.ref_bit = 1'b0;
            cbfm_pkg::WR_FILL:
            begin
                wr_word.ref_bit  = 1'b1;
                wr_word.dirty    = 1'b0;
                wr_word.pins     = cbfm_pkg::PIN_W'(1);
                wr_word.file_tag = fid_reg;
                wr_word.page_tag = pno_reg;
            end
            default:
                wr_word = rd_reg;
        endcase
    end

    // Tag memory: one port, read data registered
    always_ff @(posedge clk)
    begin
        if (cmd.wr != cbfm_pkg::WR_NONE)
            mem[addr] <= wr_word;
        if (cmd.mem_rd)
            rd_reg <= mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= op;
            fid_reg <= file_id;
            pno_reg <= page_no;
            md_reg  <= mark_dirty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hand_reg  <= LAST_IDX;
            idx_reg   <= '0;
            steps_reg <= '0;
        end
        else
        begin
            if (cmd.wr == cbfm_pkg::WR_FILL)
                valid_reg[addr] <= 1'b1;
            else if (cmd.valid_clr)
                valid_reg[addr] <= 1'b0;
            if (cmd.hand_inc)
                hand_reg <= (hand_reg == LAST_IDX) ? '0 : hand_reg + IW'(1);
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + IW'(1);
            if (cmd.steps_clr)
                steps_reg <= '0;
            else if (cmd.steps_inc)
                steps_reg <= steps_reg + SW'(1);
        end
    end

    always_comb
    begin
        frame_next  = '0;
        hit_next    = 1'b0;
        fetch_next  = 1'b0;
        wbv_next    = 1'b0;
        wbf_next    = '0;
        wbp_next    = '0;
        status_next = cbfm_pkg::STS_OK;
        last_next   = 1'b1;
        case (cmd.res)
            cbfm_pkg::RES_HIT:
            begin
                frame_next = cbfm_pkg::FRM_W'(idx_reg);
                hit_next   = 1'b1;
            end
            cbfm_pkg::RES_NOT_PINNED:
            begin
                frame_next  = cbfm_pkg::FRM_W'(idx_reg);
                hit_next    = 1'b1;
                status_next = cbfm_pkg::STS_NOT_PINNED;
            end
            cbfm_pkg::RES_EXCEEDED:
                status_next = cbfm_pkg::STS_EXCEEDED;
            cbfm_pkg::RES_FILL:
            begin
                frame_next = cbfm_pkg::FRM_W'(hand_reg);
                fetch_next = (op_reg == cbfm_pkg::OP_READ);
                if (vld && rd_reg.dirty)
                begin
                    wbv_next = 1'b1;
                    wbf_next = rd_reg.file_tag;
                    wbp_next = rd_reg.page_tag;
                end
            end
            cbfm_pkg::RES_FLUSH:
            begin
                frame_next = cbfm_pkg::FRM_W'(hand_reg);
                last_next  = 1'b0;
                if (rd_reg.dirty)
                begin
                    wbv_next = 1'b1;
                    wbf_next = rd_reg.file_tag;
                    wbp_next = rd_reg.page_tag;
                end
            end
            cbfm_pkg::RES_PINNED:
            begin
                frame_next  = cbfm_pkg::FRM_W'(hand_reg);
                status_next = cbfm_pkg::STS_PINNED;
            end
            default:
                last_next = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            frame_reg  <= frame_next;
            hit_reg    <= hit_next;
            fetch_reg  <= fetch_next;
            wbv_reg    <= wbv_next;
            wbf_reg    <= wbf_next;
            wbp_reg    <= wbp_next;
            status_reg <= status_next;
            last_reg   <= last_next;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.frame    = frame_reg;
    assign rsp.hit      = hit_reg;
    assign rsp.fetch    = fetch_reg;
    assign rsp.wb_valid = wbv_reg;
    assign rsp.wb_file  = wbf_reg;
    assign rsp.wb_page  = wbp_reg;
    assign rsp.status   = status_reg;
    assign rsp.last     = last_reg;

endmodule

[design/cbfm_ctrl.sv]
`include "clock_buffer_frame_manager_defines.svh"

module cbfm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cbfm_pkg::sts_t  sts,
    output cbfm_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LK_RD,
        ST_LK_EV,
        ST_SW_RD,
        ST_SW_EV,
        ST_FL_RD,
        ST_FL_EV,
        ST_ZERO
    } state_t;

    state_t state_reg, state_next;
    logic   accept_now;
    logic   sweep_stop;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept_now = in_valid && in_ready;
    assign sweep_stop = (state_reg == ST_SW_EV) && sts.out_free && sts.busy && sts.sweep_limit;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch   = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.op)
                    cbfm_pkg::OP_READ, cbfm_pkg::OP_UNPIN,
                    cbfm_pkg::OP_PLACE, cbfm_pkg::OP_DISPOSE:
                        state_next = ST_LK_RD;
                    cbfm_pkg::OP_FLUSH:
                    begin
                        cmd.hand_inc  = 1'b1;
                        cmd.steps_clr = 1'b1;
                        state_next    = ST_FL_RD;
                    end
                    default:
                        state_next = ST_ZERO;
                endcase
            end
            ST_LK_RD:
            begin
                cmd.mem_rd = 1'b1;
                state_next = ST_LK_EV;
            end
            ST_LK_EV:
            begin
                if (sts.out_free)
                begin
                    if (sts.match)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.res      = cbfm_pkg::RES_HIT;
                        state_next   = ST_IDLE;
                        case (sts.op)
                            cbfm_pkg::OP_UNPIN:
                            begin
                                if (sts.pins_zero)
                                    cmd.res = cbfm_pkg::RES_NOT_PINNED;
                                else
                                    cmd.wr = cbfm_pkg::WR_UNPIN;
                            end
                            cbfm_pkg::OP_DISPOSE:
                                cmd.valid_clr = 1'b1;
                            default:
                                cmd.wr = cbfm_pkg::WR_TOUCH;
                        endcase
                    end
                    else if (sts.idx_last)
                    begin
                        if (sts.op == cbfm_pkg::OP_READ || sts.op == cbfm_pkg::OP_PLACE)
                        begin
                            cmd.hand_inc  = 1'b1;
                            cmd.steps_clr = 1'b1;
                            state_next    = ST_SW_RD;
                        end
                        else
                        begin
                            cmd.out_load = 1'b1;
                            cmd.res      = cbfm_pkg::RES_ZERO;
                            state_next   = ST_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_LK_RD;
                    end
                end
            end
            ST_SW_RD:
            begin
                cmd.use_hand = 1'b1;
                cmd.mem_rd   = 1'b1;
                state_next   = ST_SW_EV;
            end
            ST_SW_EV:
            begin
                cmd.use_hand = 1'b1;
                if (sts.out_free)
                begin
                    if (sts.busy)
                    begin
                        cmd.wr        = cbfm_pkg::WR_SWEEP_CLR;
                        cmd.hand_inc  = 1'b1;
                        cmd.steps_inc = 1'b1;
                        if (sts.sweep_limit)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.res      = cbfm_pkg::RES_EXCEEDED;
                            state_next   = ST_IDLE;
                        end
                        else
                            state_next = ST_SW_RD;
                    end
                    else
                    begin
                        cmd.wr       = cbfm_pkg::WR_FILL;
                        cmd.out_load = 1'b1;
                        cmd.res      = cbfm_pkg::RES_FILL;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_FL_RD:
            begin
                cmd.use_hand = 1'b1;
                cmd.mem_rd   = 1'b1;
                state_next   = ST_FL_EV;
            end
            ST_FL_EV:
            begin
                cmd.use_hand = 1'b1;
                if (sts.out_free)
                begin
                    if (sts.file_match && !sts.pins_zero)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.res      = cbfm_pkg::RES_PINNED;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        if (sts.file_match)
                        begin
                            cmd.out_load  = 1'b1;
                            cmd.res       = cbfm_pkg::RES_FLUSH;
                            cmd.valid_clr = 1'b1;
                        end
                        cmd.hand_inc = 1'b1;
                        if (sts.flush_last)
                            state_next = ST_ZERO;
                        else
                        begin
                            cmd.steps_inc = 1'b1;
                            state_next    = ST_FL_RD;
                        end
                    end
                end
            end
            ST_ZERO:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.res      = cbfm_pkg::RES_ZERO;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `CBFM_ASSERT_NOW(a_load_when_free, cmd.out_load, sts.out_free, "load over pending result")
    `CBFM_ASSERT_NOW(a_rd_wr_apart, cmd.mem_rd, cmd.wr == cbfm_pkg::WR_NONE, "read with write")
    `CBFM_ASSERT_NEXT(a_accept_dispatch, accept_now, state_reg == ST_DISPATCH, "no dispatch")
    `CBFM_ASSERT_NEXT(a_sweep_stop, sweep_stop, state_reg == ST_IDLE, "sweep ran past its limit")

endmodule

[design/clock_buffer_frame_manager.sv]
// Channel | Role | Payload
// req     | sink   | op, file_id, page_no, mark_dirty
// rsp     | source | frame, hit, fetch, wb_valid, wb_file, wb_page, status, last
//
// One item at a time. Each frame visit is a tag memory read, then an evaluate step,
// because the tag memory has a single port with registered read data.
// Read/place: a lookup miss goes on to a clock sweep, which ends in a fill or an exceeded status.
// Unpin/dispose: lookup only, no sweep; flush walks the frames and is held by result stalls.
// Reset clears valid bits, the hand (to N-1) and the controller; no clearing pass.
// A waiting result holds every evaluate step until it is taken; req is ready only while idle.
module clock_buffer_frame_manager #(
    parameter int NUM_FRAMES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    cbfm_req_if.sink    req,
    cbfm_rsp_if.source  rsp
);

    cbfm_pkg::cmd_t cmd;
    cbfm_pkg::sts_t sts;
    logic           in_ready;

    assign req.ready = in_ready;

    // Sequencer: lookup, clock sweep and flush walk
    cbfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Frame state, tag memory, hand and result register
    cbfm_datapath #(
        .NUM_FRAMES (NUM_FRAMES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (req.op),
        .file_id    (req.file_id),
        .page_no    (req.page_no),
        .mark_dirty (req.mark_dirty),
        .cmd        (cmd),
        .sts        (sts),
        .rsp        (rsp)
    );

endmodule

[tb/tb_clock_buffer_frame_manager.sv]
module tb_clock_buffer_frame_manager;

    localparam int NF         = 16;
    localparam int N_RANDOM   = 430;
    localparam int DRAIN_WAIT = 200;
    localparam int CYCLE_CAP  = 1000000;
    localparam logic [cbfm_pkg::OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [cbfm_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [cbfm_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

    typedef struct packed {
        logic [cbfm_pkg::FRM_W-1:0]  frame;
        logic                        hit;
        logic                        fetch;
        logic                        wb_valid;
        logic [cbfm_pkg::FILE_W-1:0] wb_file;
        logic [cbfm_pkg::PAGE_W-1:0] wb_page;
        logic [cbfm_pkg::ST_W-1:0]   status;
        logic                        last;
    } frame_rsp_t;

    typedef struct packed {
        logic [cbfm_pkg::OP_W-1:0]   op;
        logic [cbfm_pkg::FILE_W-1:0] file_id;
        logic [cbfm_pkg::PAGE_W-1:0] page_no;
        logic                        mark_dirty;
        logic                        typed;
        frame_rsp_t                  want;
    } dir_row_t;

    localparam frame_rsp_t ZERO_RSP = '{0, 0, 0, 0, 0, 0, cbfm_pkg::STS_OK, 1};

    // Short hand-written sequence; typed rows carry an expectation read off by eye
    localparam int N_DIR = 20;
    localparam dir_row_t DIR_TAB [N_DIR] = '{
        '{cbfm_pkg::OP_READ,    8'h00, 32'h0,        0, 1, '{0, 0, 1, 0, 0, 0, cbfm_pkg::STS_OK, 1}},
        '{cbfm_pkg::OP_READ,    8'hFF, 32'hFFFFFFFF, 0, 1, '{1, 0, 1, 0, 0, 0, cbfm_pkg::STS_OK, 1}},
        '{cbfm_pkg::OP_READ,    8'h00, 32'h0,        0, 1, '{0, 1, 0, 0, 0, 0, cbfm_pkg::STS_OK, 1}},
        '{cbfm_pkg::OP_UNPIN,   8'h00, 32'h0,        1, 1, '{0, 1, 0, 0, 0, 0, cbfm_pkg::STS_OK, 1}},
        '{cbfm_pkg::OP_UNPIN,   8'h00, 32'h0,        0, 1, '{0, 1, 0, 0, 0, 0, cbfm_pkg::STS_OK, 1}},
        '{cbfm_pkg::OP_UNPIN,   8'h00, 32'h0,        1, 1,
          '{0, 1, 0, 0, 0, 0, cbfm_pkg::STS_NOT_PINNED, 1}},
        '{cbfm_pkg::OP_UNPIN,   8'h07, 32'h7,        1, 1, ZERO_RSP},
        '{cbfm_pkg::OP_DISPOSE, 8'h07, 32'h7,        0, 1, ZERO_RSP},
        '{cbfm_pkg::OP_PLACE,   8'h12, 32'h34,       0, 0, ZERO_RSP},
        '{cbfm_pkg::OP_PLACE,   8'h12, 32'h34,       0, 0, ZERO_RSP},
        '{OP_SPARE5,            8'hFF, 32'hFFFFFFFF, 1, 1, ZERO_RSP},
        '{OP_SPARE6,            8'h00, 32'h0,        0, 1, ZERO_RSP},
        '{OP_SPARE7,            8'hAA, 32'h55555555, 1, 1, ZERO_RSP},
        '{cbfm_pkg::OP_FLUSH,   8'h00, 32'hFFFFFFFF, 0, 0, ZERO_RSP},
        '{cbfm_pkg::OP_FLUSH,   8'hFF, 32'h0,        0, 0, ZERO_RSP},
        '{cbfm_pkg::OP_UNPIN,   8'hFF, 32'hFFFFFFFF, 1, 0, ZERO_RSP},
        '{cbfm_pkg::OP_FLUSH,   8'hFF, 32'h0,        1, 0, ZERO_RSP},
        '{cbfm_pkg::OP_DISPOSE, 8'h12, 32'h34,       0, 0, ZERO_RSP},
        '{cbfm_pkg::OP_FLUSH,   8'h12, 32'h0,        0, 0, ZERO_RSP},
        '{cbfm_pkg::OP_READ,    8'h80, 32'h80000000, 0, 0, ZERO_RSP}
    };

    logic clk;
    logic rst_n;

    cbfm_req_if req_ch ();
    cbfm_rsp_if rsp_ch ();

    clock_buffer_frame_manager #(.NUM_FRAMES(NF)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow of the frame table
    logic                        sh_valid [NF];
    logic                        sh_ref   [NF];
    logic                        sh_dirty [NF];
    logic [cbfm_pkg::PIN_W-1:0]  sh_pins  [NF];
    logic [cbfm_pkg::FILE_W-1:0] sh_file  [NF];
    logic [cbfm_pkg::PAGE_W-1:0] sh_page  [NF];
    logic [cbfm_pkg::FRM_W-1:0]  sh_hand;

    frame_rsp_t pending_rsp [$];
    int         mismatches;
    int         cycles;
    int         phase;      // 0 none, 1 sender idle, 2 receiver stall, 3 both light

    // Pools that keep hits, evictions and full-buffer sweeps frequent
    logic [cbfm_pkg::FILE_W-1:0] file_pool [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    logic [cbfm_pkg::PAGE_W-1:0] page_pool [8];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    // Work out the results one request causes and advance the shadow table
    task automatic predict_frames(input logic [cbfm_pkg::OP_W-1:0] op,
                                  input logic [cbfm_pkg::FILE_W-1:0] fid,
                                  input logic [cbfm_pkg::PAGE_W-1:0] pno, input logic md,
                                  ref frame_rsp_t res [$]);
        int                         hf;
        int                         steps;
        bit                         found;
        logic [cbfm_pkg::FRM_W-1:0] c;
        frame_rsp_t                 r;
        hf = -1;
        for (int i = 0; i < NF; i++)
        begin
            if (hf < 0 && sh_valid[i] && sh_file[i] == fid && sh_page[i] == pno)
                hf = i;
        end
        r = '0;
        r.last = 1'b1;
        case (op)
            cbfm_pkg::OP_READ, cbfm_pkg::OP_PLACE:
            begin
                if (hf >= 0)
                begin
                    sh_ref[hf] = 1'b1;
                    if (sh_pins[hf] != cbfm_pkg::PIN_MAX)
                        sh_pins[hf] = sh_pins[hf] + 1'b1;
                    r.frame = cbfm_pkg::FRM_W'(hf);
                    r.hit   = 1'b1;
                end
                else
                begin
                    // second-chance sweep: clear reference bits until a free victim
                    found = 1'b1;
                    steps = 0;
                    sh_hand = sh_hand + 1'b1;
                    while (found && sh_valid[sh_hand] &&
                           (sh_ref[sh_hand] || sh_pins[sh_hand] != '0))
                    begin
                        sh_ref[sh_hand] = 1'b0;
                        sh_hand = sh_hand + 1'b1;
                        steps++;
                        if (steps == 2 * NF - 1)
                            found = 1'b0;
                    end
                    if (!found)
                        r.status = cbfm_pkg::STS_EXCEEDED;
                    else
                    begin
                        if (sh_valid[sh_hand] && sh_dirty[sh_hand])
                        begin
                            r.wb_valid = 1'b1;
                            r.wb_file  = sh_file[sh_hand];
                            r.wb_page  = sh_page[sh_hand];
                        end
                        sh_valid[sh_hand] = 1'b1;
                        sh_ref[sh_hand]   = 1'b1;
                        sh_dirty[sh_hand] = 1'b0;
                        sh_pins[sh_hand]  = cbfm_pkg::PIN_W'(1);
                        sh_file[sh_hand]  = fid;
                        sh_page[sh_hand]  = pno;
                        r.frame = sh_hand;
                        r.fetch = (op == cbfm_pkg::OP_READ);
                    end
                end
                res.push_back(r);
            end
            cbfm_pkg::OP_UNPIN:
            begin
                if (hf >= 0)
                begin
                    r.frame = cbfm_pkg::FRM_W'(hf);
                    r.hit   = 1'b1;
                    if (sh_pins[hf] == '0)
                        r.status = cbfm_pkg::STS_NOT_PINNED;
                    else
                    begin
                        sh_pins[hf] = sh_pins[hf] - 1'b1;
                        if (md)
                            sh_dirty[hf] = 1'b1;
                    end
                end
                res.push_back(r);
            end
            cbfm_pkg::OP_DISPOSE:
            begin
                if (hf >= 0)
                begin
                    sh_valid[hf] = 1'b0;
                    sh_ref[hf]   = 1'b0;
                    sh_dirty[hf] = 1'b0;
                    sh_pins[hf]  = '0;
                    r.frame = cbfm_pkg::FRM_W'(hf);
                    r.hit   = 1'b1;
                end
                res.push_back(r);
            end
            cbfm_pkg::OP_FLUSH:
            begin
                sh_hand = sh_hand + 1'b1;
                for (int k = 0; k < NF; k++)
                begin
                    c = sh_hand;
                    if (sh_valid[c] && sh_file[c] == fid)
                    begin
                        r = '0;
                        r.frame = c;
                        if (sh_pins[c] != '0)
                        begin
                            // a pinned frame ends the flush
                            r.status = cbfm_pkg::STS_PINNED;
                            r.last   = 1'b1;
                            res.push_back(r);
                            return;
                        end
                        if (sh_dirty[c])
                        begin
                            r.wb_valid = 1'b1;
                            r.wb_file  = sh_file[c];
                            r.wb_page  = sh_page[c];
                        end
                        res.push_back(r);
                        sh_valid[c] = 1'b0;
                        sh_ref[c]   = 1'b0;
                        sh_dirty[c] = 1'b0;
                        sh_pins[c]  = '0;
                    end
                    sh_hand = sh_hand + 1'b1;
                end
                r = '0;
                r.last = 1'b1;
                res.push_back(r);
            end
            default:
                res.push_back(r);
        endcase
    endtask

    function automatic bit sender_idle();
        case (phase)
            1: return $urandom_range(99) < 74;
            3: return $urandom_range(99) < 22;
            default: return 1'b0;
        endcase
    endfunction

    // Offer one item from the falling edge; hold it until the block takes it
    task automatic send_item(input logic [cbfm_pkg::OP_W-1:0] op,
                             input logic [cbfm_pkg::FILE_W-1:0] fid,
                             input logic [cbfm_pkg::PAGE_W-1:0] pno, input logic md,
                             input logic typed, input frame_rsp_t want);
        frame_rsp_t got [$];
        @(negedge clk);
        while (sender_idle())
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.file_id    <= fid;
        req_ch.page_no    <= pno;
        req_ch.mark_dirty <= md;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_frames(op, fid, pno, md, got);
        if (typed)
            pending_rsp.push_back(want);
        else
        begin
            foreach (got[i])
                pending_rsp.push_back(got[i]);
        end
    endtask

    // Receiver: stall according to the phase, decided at the falling edge
    always @(negedge clk)
    begin
        case (phase)
            2: rsp_ch.ready <= ($urandom_range(99) >= 74);
            3: rsp_ch.ready <= ($urandom_range(99) >= 22);
            default: rsp_ch.ready <= 1'b1;
        endcase
    end

    // Compare every accepted result with the oldest pending one
    always @(posedge clk)
    begin
        frame_rsp_t seen;
        frame_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen = '{rsp_ch.frame, rsp_ch.hit, rsp_ch.fetch, rsp_ch.wb_valid,
                     rsp_ch.wb_file, rsp_ch.wb_page, rsp_ch.status, rsp_ch.last};
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected: frame %0d hit %0b fetch %0b wb %0b/%h/%h st %0d last %0b",
                             seen.frame, seen.hit, seen.fetch, seen.wb_valid, seen.wb_file,
                             seen.wb_page, seen.status, seen.last);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("expected: frame %0d hit %0b fetch %0b wb %0b/%h/%h st %0d l %0b",
                                 want.frame, want.hit, want.fetch, want.wb_valid, want.wb_file,
                                 want.wb_page, want.status, want.last);
                        $display("actual:   frame %0d hit %0b fetch %0b wb %0b/%h/%h st %0d l %0b",
                                 seen.frame, seen.hit, seen.fetch, seen.wb_valid, seen.wb_file,
                                 seen.wb_page, seen.status, seen.last);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("clock_buffer_frame_manager regression: fail");
            $finish;
        end
    end

    initial
    begin
        int                          pick;
        logic [cbfm_pkg::OP_W-1:0]   op;
        logic [cbfm_pkg::FILE_W-1:0] fid;
        logic [cbfm_pkg::PAGE_W-1:0] pno;
        mismatches = 0;
        cycles     = 0;
        phase      = 0;
        rst_n      = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.op         = cbfm_pkg::OP_READ;
        req_ch.file_id    = '0;
        req_ch.page_no    = '0;
        req_ch.mark_dirty = 1'b0;
        rsp_ch.ready      = 1'b1;
        for (int i = 0; i < NF; i++)
        begin
            sh_valid[i] = 1'b0;
            sh_ref[i]   = 1'b0;
            sh_dirty[i] = 1'b0;
            sh_pins[i]  = '0;
            sh_file[i]  = '0;
            sh_page[i]  = '0;
        end
        sh_hand = cbfm_pkg::FRM_W'(NF - 1);
        page_pool[0] = 32'h0;
        page_pool[1] = 32'hFFFFFFFF;
        for (int i = 2; i < 8; i++)
            page_pool[i] = $urandom;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIR_TAB[i])
            send_item(DIR_TAB[i].op, DIR_TAB[i].file_id, DIR_TAB[i].page_no,
                      DIR_TAB[i].mark_dirty, DIR_TAB[i].typed, DIR_TAB[i].want);

        // Random traffic: mostly pooled pages so the buffer fills and sweeps run deep
        for (int n = 0; n < N_RANDOM; n++)
        begin
            phase = (n * 4) / N_RANDOM;
            pick  = $urandom_range(99);
            if (pick < 35)
                op = cbfm_pkg::OP_READ;
            else if (pick < 45)
                op = cbfm_pkg::OP_PLACE;
            else if (pick < 75)
                op = cbfm_pkg::OP_UNPIN;
            else if (pick < 85)
                op = cbfm_pkg::OP_DISPOSE;
            else if (pick < 95)
                op = cbfm_pkg::OP_FLUSH;
            else
                op = cbfm_pkg::OP_W'($urandom_range(OP_SPARE7, OP_SPARE5));
            if ($urandom_range(9) == 0)
            begin
                fid = cbfm_pkg::FILE_W'($urandom);
                pno = $urandom;
            end
            else
            begin
                fid = file_pool[$urandom_range(3)];
                pno = page_pool[$urandom_range(7)];
            end
            send_item(op, fid, pno, 1'($urandom_range(1)), 1'b0, ZERO_RSP);
        end
        @(negedge clk);
        req_ch.valid <= 1'b0;

        // Drain, then give the block time to show any stray result
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("clock_buffer_frame_manager regression: pass");
        else
            $display("clock_buffer_frame_manager regression: fail");
        $finish;
    end

endmodule

[clock_buffer_frame_manager.f]
+incdir+design
design/cbfm_pkg.sv
design/cbfm_req_if.sv
design/cbfm_rsp_if.sv
design/cbfm_datapath.sv
design/cbfm_ctrl.sv
design/clock_buffer_frame_manager.sv
tb/tb_clock_buffer_frame_manager.sv
